/* hw/rtl/bahd_pkg.sv */
// ----------------------------------------------------------------------------
// bahd_pkg
// Types, constants and character helpers shared by the Basic auth decoder.
// ----------------------------------------------------------------------------
package bahd_pkg;

    // default limits
    localparam int USER_MAX_DEF    = 32;
    localparam int PASS_LIMIT_DEF  = 64;
    localparam int MAX_ENCODED_DEF = 128;

    // result queue depth, power of two
    localparam int RQ_DEPTH = 4;

    localparam int AUTH_LEN  = 14;
    localparam int BASIC_LEN = 6;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_A_LO  = 8'h61;

    localparam logic [1:0] PART_USER    = 2'd0;
    localparam logic [1:0] PART_PASS    = 2'd1;
    localparam logic [1:0] PART_VERDICT = 2'd2;

    typedef enum logic [2:0] {
        VD_OK       = 3'd0,
        VD_PREFIX   = 3'd1,
        VD_LENGTH   = 3'd2,
        VD_CHAR     = 3'd3,
        VD_OVERFLOW = 3'd4,
        VD_COLON    = 3'd5,
        VD_FIELDS   = 3'd6
    } t_verdict;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       end_of_header;
    } t_in_item;

    typedef struct packed {
        logic [1:0] part;
        logic [7:0] value;
        logic [2:0] verdict;
        logic       final_res;
    } t_out_item;

    // up to two words per input word: a decoded byte, then the verdict
    typedef struct packed {
        logic      byte_vld;
        t_out_item byte_item;
        logic      vdt_vld;
        t_out_item vdt_item;
    } t_step_res;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // "authorization:"
    function automatic logic [7:0] auth_char(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = 8'h61;
            4'd1:    r = 8'h75;
            4'd2:    r = 8'h74;
            4'd3:    r = 8'h68;
            4'd4:    r = 8'h6F;
            4'd5:    r = 8'h72;
            4'd6:    r = 8'h69;
            4'd7:    r = 8'h7A;
            4'd8:    r = 8'h61;
            4'd9:    r = 8'h74;
            4'd10:   r = 8'h69;
            4'd11:   r = 8'h6F;
            4'd12:   r = 8'h6E;
            4'd13:   r = 8'h3A;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // "basic "
    function automatic logic [7:0] basic_char(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = 8'h62;
            3'd1:    r = 8'h61;
            3'd2:    r = 8'h73;
            3'd3:    r = 8'h69;
            3'd4:    r = 8'h63;
            3'd5:    r = 8'h20;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // {valid, 6-bit sextet}
    function automatic logic [6:0] b64_decode(input logic [7:0] c);
        logic [6:0] r;
        r = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h47)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c + 8'd4)};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

/* hw/rtl/bahd_core.sv */
// ----------------------------------------------------------------------------
// bahd_core
// Per-word parse/decode step: prefix match, base64 decode, user/password
// split and final verdict. State updates on every advanced word.
// ----------------------------------------------------------------------------
module bahd_core #(
    parameter int USER_MAX    = bahd_pkg::USER_MAX_DEF,
    parameter int PASS_LIMIT  = bahd_pkg::PASS_LIMIT_DEF,
    parameter int MAX_ENCODED = bahd_pkg::MAX_ENCODED_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  bahd_pkg::t_in_item  i_item,
    output bahd_pkg::t_step_res o_res
);
    import bahd_pkg::*;

    localparam int DEC_CAP = USER_MAX + PASS_LIMIT + 3;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_AUTH   = 3'd1,
        PH_BLANK2 = 3'd2,
        PH_BASIC  = 3'd3,
        PH_BLANK3 = 3'd4,
        PH_DATA   = 3'd5,
        PH_IGNORE = 3'd6
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [3:0] pidx;
        logic [13:0] acc;
        logic [3:0] bit_cnt;
        logic [7:0] enc_cnt;
        logic [7:0] trail;
        logic [7:0] dec_cnt;
        logic [6:0] ulen;
        logic       colon;
        logic       stopped;
        logic       ptab;
        t_verdict   err;
    } t_core_state;

    t_core_state r_st;
    t_core_state n_st;
    t_core_state upd;

    logic [7:0] c;
    logic [7:0] lc;
    logic       blank;
    logic       done;
    logic       last;
    logic [6:0] b64;
    logic [8:0] sum;
    logic [3:0] bc6;
    logic [7:0] dbyte;
    logic [7:0] plen;
    t_verdict   vd;
    t_step_res  res;

    always_comb begin
        upd   = r_st;
        c     = i_item.header_byte;
        lc    = to_lower(i_item.header_byte);
        blank = (c == CH_SPACE) || (c == CH_TAB);
        b64   = b64_decode(c);
        last  = (c == CH_NUL) || i_item.end_of_header;
        done  = 1'b0;
        sum   = '0;
        bc6   = '0;
        dbyte = '0;
        plen  = '0;
        vd    = VD_OK;
        res   = '0;

        if (c != CH_NUL) begin
            if (upd.phase == PH_LEAD) begin
                if (blank) begin
                    done = 1'b1;
                end else if (lc == CH_A_LO) begin
                    upd.phase = PH_AUTH;
                    upd.pidx  = 4'd1;
                    done      = 1'b1;
                end else begin
                    upd.phase = PH_BASIC;
                    upd.pidx  = '0;
                end
            end
            if (!done && upd.phase == PH_AUTH) begin
                done = 1'b1;
                if (upd.pidx < 4'(AUTH_LEN) && lc == auth_char(upd.pidx)) begin
                    upd.pidx = upd.pidx + 4'd1;
                    if (upd.pidx == 4'(AUTH_LEN)) begin
                        upd.phase = PH_BLANK2;
                    end
                end else begin
                    upd.err   = VD_PREFIX;
                    upd.phase = PH_IGNORE;
                end
            end
            if (!done && upd.phase == PH_BLANK2) begin
                if (blank) begin
                    done = 1'b1;
                end else begin
                    upd.phase = PH_BASIC;
                    upd.pidx  = '0;
                end
            end
            if (!done && upd.phase == PH_BASIC) begin
                done = 1'b1;
                if (upd.pidx < 4'(BASIC_LEN) && lc == basic_char(upd.pidx[2:0])) begin
                    upd.pidx = upd.pidx + 4'd1;
                    if (upd.pidx == 4'(BASIC_LEN)) begin
                        upd.phase = PH_BLANK3;
                    end
                end else begin
                    upd.err   = VD_PREFIX;
                    upd.phase = PH_IGNORE;
                end
            end
            if (!done && upd.phase == PH_BLANK3) begin
                if (blank) begin
                    done = 1'b1;
                end else begin
                    upd.phase = PH_DATA;
                end
            end
            if (!done && upd.phase == PH_DATA) begin
                if (c == CH_CR || c == CH_LF) begin
                    upd.phase = PH_IGNORE;
                end else if (blank) begin
                    if (upd.trail != 8'hFF) begin
                        upd.trail = upd.trail + 8'd1;
                    end
                    // a tab only goes bad if text follows it
                    if (!upd.stopped) begin
                        if (c == CH_TAB) begin
                            upd.ptab = 1'b1;
                        end else if (!upd.ptab) begin
                            upd.stopped = 1'b1;
                        end
                    end
                end else begin
                    sum       = {1'b0, upd.enc_cnt} + {1'b0, upd.trail} + 9'd1;
                    upd.trail = '0;
                    if (sum > 9'(MAX_ENCODED)) begin
                        upd.err = VD_LENGTH;
                    end
                    upd.enc_cnt = sum[8] ? 8'hFF : sum[7:0];
                    if (upd.stopped) begin
                        // counted, not decoded
                    end else if (upd.ptab || !b64[6] && c != CH_EQ) begin
                        if (upd.err == VD_OK) begin
                            upd.err = VD_CHAR;
                        end
                        upd.stopped = 1'b1;
                    end else if (c == CH_EQ) begin
                        upd.stopped = 1'b1;
                    end else begin
                        upd.acc = {upd.acc[7:0], b64[5:0]};
                        bc6     = upd.bit_cnt + 4'd6;
                        if (bc6 < 4'd8) begin
                            upd.bit_cnt = bc6;
                        end else begin
                            upd.bit_cnt = bc6 - 4'd8;
                            if (upd.dec_cnt >= 8'(DEC_CAP)) begin
                                if (upd.err == VD_OK) begin
                                    upd.err = VD_OVERFLOW;
                                end
                                upd.stopped = 1'b1;
                            end else begin
                                dbyte       = 8'(upd.acc >> upd.bit_cnt);
                                upd.dec_cnt = upd.dec_cnt + 8'd1;
                                if (upd.colon) begin
                                    res.byte_vld        = 1'b1;
                                    res.byte_item.part  = PART_PASS;
                                    res.byte_item.value = dbyte;
                                end else if (dbyte == CH_COLON) begin
                                    upd.colon = 1'b1;
                                end else begin
                                    if (upd.ulen != 7'h7F) begin
                                        upd.ulen = upd.ulen + 7'd1;
                                    end
                                    res.byte_vld        = 1'b1;
                                    res.byte_item.part  = PART_USER;
                                    res.byte_item.value = dbyte;
                                end
                            end
                        end
                    end
                end
            end
        end

        // verdict, in priority order
        if (upd.err == VD_PREFIX || upd.phase < PH_BLANK3) begin
            vd = VD_PREFIX;
        end else if (upd.err == VD_LENGTH || upd.enc_cnt == '0) begin
            vd = VD_LENGTH;
        end else if (upd.err != VD_OK) begin
            vd = upd.err;
        end else if (!upd.colon) begin
            vd = VD_COLON;
        end else if (upd.ulen == '0 || upd.ulen > 7'(USER_MAX)) begin
            vd = VD_FIELDS;
        end else if ({1'b0, upd.dec_cnt} < ({2'b0, upd.ulen} + 9'd1)) begin
            vd = VD_FIELDS;
        end else begin
            plen = upd.dec_cnt - {1'b0, upd.ulen} - 8'd1;
            if (plen == '0 || {1'b0, plen} >= 9'(PASS_LIMIT)) begin
                vd = VD_FIELDS;
            end
        end

        n_st = upd;
        if (last) begin
            res.vdt_vld            = 1'b1;
            res.vdt_item.part      = PART_VERDICT;
            res.vdt_item.verdict   = vd;
            res.vdt_item.final_res = 1'b1;
            n_st       = '0;
            n_st.phase = PH_LEAD;
        end

        o_res          = res;
        o_res.byte_vld = res.byte_vld && i_adv;
        o_res.vdt_vld  = res.vdt_vld && i_adv;
    end

    // all-zero state is the leading blank skip phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_adv) begin
            r_st <= n_st;
        end
    end

    a_bitcnt_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.bit_cnt == 4'd0 || r_st.bit_cnt == 4'd2 ||
        r_st.bit_cnt == 4'd4 || r_st.bit_cnt == 4'd6)
        else $error("bit count out of range");

    a_verdict_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.vdt_vld |=> r_st.phase == PH_LEAD && r_st.dec_cnt == '0 &&
        r_st.err == VD_OK)
        else $error("state not cleared after verdict");

    a_dec_needs_enc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.dec_cnt != '0 |-> r_st.enc_cnt != '0)
        else $error("decoded bytes without encoded chars");

endmodule

/* hw/rtl/bahd_rfifo.sv */
// ----------------------------------------------------------------------------
// bahd_rfifo
// Small result queue: takes up to two words per cycle, hands out one per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module bahd_rfifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bahd_pkg::t_step_res i_res,
    output logic                o_room2,
    output logic                o_valid,
    input  logic                i_ready,
    output bahd_pkg::t_out_item o_data
);
    import bahd_pkg::*;

    localparam int PTR_W = $clog2(RQ_DEPTH);
    localparam int CNT_W = $clog2(RQ_DEPTH + 1);

    t_out_item          mem [RQ_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic [PTR_W-1:0]   wr_nx;
    logic [1:0]         push_n;
    logic               pop;

    assign push_n  = {1'b0, i_res.byte_vld} + {1'b0, i_res.vdt_vld};
    assign pop     = o_valid && i_ready;
    assign wr_nx   = r_wr + PTR_W'(1);
    assign o_valid = (r_cnt != '0);
    assign o_data  = mem[r_rd];
    assign o_room2 = (r_cnt <= CNT_W'(RQ_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_res.byte_vld) begin
            mem[r_wr] <= i_res.byte_item;
        end
        if (i_res.vdt_vld) begin
            mem[i_res.byte_vld ? wr_nx : r_wr] <= i_res.vdt_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PTR_W'(push_n);
            r_rd  <= r_rd + PTR_W'(pop);
            r_cnt <= r_cnt + CNT_W'(push_n) - CNT_W'(pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(RQ_DEPTH))
        else $error("result queue count overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_n != 2'd0 |-> o_room2)
        else $error("push without room");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> r_wr == r_rd)
        else $error("pointers differ on empty queue");

endmodule

/* hw/rtl/basic_auth_header_decoder.sv */
// Path: an accepted word is held in the input register, stepped by the core
// once the result queue has room, and its results are read out of that queue.
// Throughput: one header byte per cycle while the result queue has room for
// two words; a word yields at most two results (decoded byte, verdict).
// Reset: synchronous, active low; parser state and result queue are cleared.
// ----------------------------------------------------------------------------
// basic_auth_header_decoder
// Streams an HTTP Basic authorization header, decodes base64 credentials
// into user/password bytes and closes each header with a verdict word.
// ----------------------------------------------------------------------------
module basic_auth_header_decoder #(
    parameter int USER_MAX    = bahd_pkg::USER_MAX_DEF,
    parameter int PASS_LIMIT  = bahd_pkg::PASS_LIMIT_DEF,
    parameter int MAX_ENCODED = bahd_pkg::MAX_ENCODED_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bahd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bahd_pkg::t_out_item o_out_data
);
    import bahd_pkg::*;

    logic      r_in_vld;
    t_in_item  r_in;
    logic      room2;
    logic      adv;
    logic      in_acc;
    t_step_res step_res;

    assign adv        = r_in_vld && room2;
    assign o_in_ready = !r_in_vld || adv;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
    end

    bahd_core #(
        .USER_MAX    (USER_MAX),
        .PASS_LIMIT  (PASS_LIMIT),
        .MAX_ENCODED (MAX_ENCODED)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_in),
        .o_res   (step_res)
    );

    bahd_rfifo u_rfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (step_res),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
